[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker in rtl/brlt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/brlt_pkg.sv]
// Package: word types, status codes and field widths of the byte-range lock table.
`default_nettype none
package brlt_pkg;

  localparam int OFFSET_FIELD_W = 48;
  localparam int OWNER_FIELD_W  = 8;
  localparam int HELD_W         = 5;
  localparam logic [HELD_W-1:0] HELD_MAX = 5'd31;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_CONFLICT  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t                       operation;
    logic [OWNER_FIELD_W-1:0]  owner_id;
    logic [OFFSET_FIELD_W-1:0] range_start;
    logic [OFFSET_FIELD_W-1:0] range_length;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [HELD_W-1:0] locks_held;
  } rsp_t;

  // Per-entry verdict of the compare unit.
  typedef struct packed {
    logic overlap_foreign;
    logic exact_match;
  } cmp_t;

endpackage
`default_nettype wire

[rtl/brlt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module brlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/brlt_cmp.sv]
// Shared compare unit: overlap against a foreign owner and exact-match test for one entry.
`default_nettype none
module brlt_cmp #(
  parameter int OW = 48,
  parameter int HW = 8
) (
  input  wire logic [OW-1:0] req_start,
  input  wire logic [OW-1:0] req_length,
  input  wire logic [OW:0]   req_end,
  input  wire logic [HW-1:0] req_owner,
  input  wire logic [OW-1:0] ent_start,
  input  wire logic [OW-1:0] ent_length,
  input  wire logic [HW-1:0] ent_owner,
  output brlt_pkg::cmp_t     res
);
  import brlt_pkg::*;

  logic [OW:0] ent_end;
  logic        disjoint;
  logic        same_owner;

  always_comb begin
    ent_end    = {1'b0, ent_start} + {1'b0, ent_length};
    disjoint   = (req_end <= {1'b0, ent_start}) || (ent_end <= {1'b0, req_start});
    same_owner = (ent_owner == req_owner);
    res.overlap_foreign = !same_owner && !disjoint;
    res.exact_match     = same_owner && (ent_start == req_start) &&
                          (ent_length == req_length);
  end

endmodule
`default_nettype wire

[rtl/byte_range_lock_table_top.sv]
// Top level: exclusive byte-range lock table with a sequential entry scan.
//
// Request channel (req_valid/req_ready/req): one word per lock request,
// acquire or release of [range_start, range_start + range_length) for owner_id.
// Response channel (rsp_valid/rsp_ready/rsp): one word per request with the
// status and the number of locks held after the request.
//
// Timing: a request scans every table entry through one RAM read port and one
// shared compare unit, one entry per cycle. From request accept to response
// valid the request passes the scan, the registered RAM read and the decision
// state, which holds while the output register is full. req_ready is high
// only while no request is in flight, so a new request is not taken until
// the last one has left the decision state.
//
// The response sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, the next request finishes its scan and holds
// in the decision cycle until the register frees up.
//
// Reset (rst, synchronous) clears all valid bits and the lock count at once;
// entry contents are stored in RAM and need no clearing.
`default_nettype none
module byte_range_lock_table_top #(
  parameter int TABLE_ENTRIES = 16,
  parameter int OFFSET_BITS   = 48,
  parameter int OWNER_BITS    = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire brlt_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output brlt_pkg::rsp_t      rsp
);
  import brlt_pkg::*;

  // Offsets and owners wider than the word fields reduce to the field width.
  localparam int OW = (OFFSET_BITS < OFFSET_FIELD_W) ? OFFSET_BITS : OFFSET_FIELD_W;
  localparam int HW = (OWNER_BITS < OWNER_FIELD_W) ? OWNER_BITS : OWNER_FIELD_W;
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int DW = HW + 2 * OW;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t state;

  // Latched request.
  op_t         op_q;
  logic [HW-1:0] own_q;
  logic [OW-1:0] st_q;
  logic [OW-1:0] len_q;
  logic [OW:0]   end_q;

  // Scan: read issue, and the compare stage working on the read issued in the previous cycle.
  logic          rd_busy;
  logic [IW-1:0] rd_idx;
  logic          p_vld;
  logic [IW-1:0] p_idx;

  // Scan results.
  logic          conflict;
  logic          found;
  logic [IW-1:0] match_idx;
  logic          have_free;
  logic [IW-1:0] free_idx;

  // Table state.
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CW-1:0]            count;

  // RAM and compare unit.
  logic          ram_we;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;
  logic [HW-1:0] ent_owner;
  logic [OW-1:0] ent_start;
  logic [OW-1:0] ent_length;
  cmp_t          cmp;

  // Decision.
  logic          can_out;
  logic          do_store;
  logic          do_remove;
  status_t       status_next;
  logic [CW-1:0] count_next;
  logic [HELD_W-1:0] held_next;

  assign req_ready = (state == S_IDLE);

  assign ram_wdata = {own_q, len_q, st_q};
  assign {ent_owner, ent_length, ent_start} = ram_rdata;

  brlt_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  brlt_cmp #(
    .OW (OW),
    .HW (HW)
  ) u_cmp (
    .req_start  (st_q),
    .req_length (len_q),
    .req_end    (end_q),
    .req_owner  (own_q),
    .ent_start  (ent_start),
    .ent_length (ent_length),
    .ent_owner  (ent_owner),
    .res        (cmp)
  );

  // Decision cycle: conflict wins over full; release takes the lowest match.
  always_comb begin
    can_out     = !rsp_valid || rsp_ready;
    do_store    = 1'b0;
    do_remove   = 1'b0;
    status_next = ST_DONE;
    count_next  = count;
    unique case (op_q)
      OP_ACQUIRE: begin
        if (conflict) begin
          status_next = ST_CONFLICT;
        end else if (!have_free) begin
          status_next = ST_FULL;
        end else begin
          do_store   = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_RELEASE: begin
        if (found) begin
          do_remove  = 1'b1;
          count_next = count - CW'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
    if (int'(count_next) > int'(HELD_MAX)) begin
      held_next = HELD_MAX;
    end else begin
      held_next = HELD_W'(count_next);
    end
    ram_we = (state == S_DECIDE) && can_out && do_store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_busy   <= 1'b0;
      p_vld     <= 1'b0;
      valid     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // New response loads, or the held one leaves.
      if ((state == S_DECIDE) && can_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q      <= req.operation;
            own_q     <= req.owner_id[HW-1:0];
            st_q      <= req.range_start[OW-1:0];
            len_q     <= req.range_length[OW-1:0];
            end_q     <= {1'b0, req.range_start[OW-1:0]} +
                         {1'b0, req.range_length[OW-1:0]};
            rd_idx    <= '0;
            rd_busy   <= 1'b1;
            p_vld     <= 1'b0;
            conflict  <= 1'b0;
            found     <= 1'b0;
            have_free <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Read side.
          p_vld <= rd_busy;
          p_idx <= rd_idx;
          if (rd_busy) begin
            if (rd_idx == LAST_IDX) begin
              rd_busy <= 1'b0;
            end else begin
              rd_idx <= rd_idx + IW'(1);
            end
          end
          // Compare side.
          if (p_vld) begin
            if (valid[p_idx]) begin
              if (cmp.overlap_foreign) begin
                conflict <= 1'b1;
              end
              if (cmp.exact_match && !found) begin
                found     <= 1'b1;
                match_idx <= p_idx;
              end
            end else if (!have_free) begin
              have_free <= 1'b1;
              free_idx  <= p_idx;
            end
            if (p_idx == LAST_IDX) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          if (can_out) begin
            if (do_store) begin
              valid[free_idx] <= 1'b1;
            end
            if (do_remove) begin
              valid[match_idx] <= 1'b0;
            end
            count          <= count_next;
            rsp.status     <= status_next;
            rsp.locks_held <= held_next;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/brlt_checker.sv]
// Port-level checker for the byte-range lock table, with its bind.
`default_nettype none
`include "assert_macros.svh"
module brlt_props #(
  parameter int TABLE_ENTRIES = 16
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire brlt_pkg::rsp_t rsp
);
  import brlt_pkg::*;

  localparam int HELD_CAP = (TABLE_ENTRIES < 31) ? TABLE_ENTRIES : 31;

  logic rsp_full;

  assign rsp_full = rsp_valid && (rsp.status == ST_FULL);

  // A request in flight blocks the next one.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)
  // Count never exceeds the table size.
  `ASSERT_IMPLIES(a_held_bound, clk, rst, rsp_valid, int'(rsp.locks_held) <= HELD_CAP)
  // Full status means every entry is held.
  `ASSERT_IMPLIES(a_full_count, clk, rst, rsp_full, int'(rsp.locks_held) == HELD_CAP)
  // Stalled response holds.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind byte_range_lock_table_top brlt_props #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_brlt_props (.*);
`default_nettype wire

[verif/brlt_checker.sv]
// Checker: predicts each lock table response and compares it with the DUT output.
`default_nettype none
module brlt_checker #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  input  wire logic           req_ready,
  input  wire brlt_pkg::req_t req,
  input  wire logic           rsp_valid,
  input  wire logic           rsp_ready,
  input  wire brlt_pkg::rsp_t rsp,
  output int                  fail_count,
  output int                  outstanding
);
  import brlt_pkg::*;

  logic                      slot_valid  [TABLE_ENTRIES];
  logic [OFFSET_FIELD_W-1:0] slot_start  [TABLE_ENTRIES];
  logic [OFFSET_FIELD_W-1:0] slot_length [TABLE_ENTRIES];
  logic [OWNER_FIELD_W-1:0]  slot_owner  [TABLE_ENTRIES];

  rsp_t pending_rsp[$];
  int   errors = 0;

  // Applies one request to the shadow table and returns the response it earns.
  function automatic rsp_t resolve_request(input req_t r);
    rsp_t                    res;
    int                      free_slot;
    int                      n;
    logic                    clash;
    logic [OFFSET_FIELD_W:0] req_end;
    logic [OFFSET_FIELD_W:0] slot_end;
    free_slot  = -1;
    clash      = 1'b0;
    n          = 0;
    res.status = ST_DONE;
    // one extra bit so the range end never wraps
    req_end = {1'b0, r.range_start} + {1'b0, r.range_length};
    if (r.operation == OP_ACQUIRE) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_valid[i]) begin
          slot_end = {1'b0, slot_start[i]} + {1'b0, slot_length[i]};
          if (slot_owner[i] != r.owner_id &&
              !(req_end <= {1'b0, slot_start[i]} || slot_end <= {1'b0, r.range_start}))
            clash = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      // conflict wins over full
      if (clash) begin
        res.status = ST_CONFLICT;
      end else if (free_slot < 0) begin
        res.status = ST_FULL;
      end else begin
        slot_valid[free_slot]  = 1'b1;
        slot_start[free_slot]  = r.range_start;
        slot_length[free_slot] = r.range_length;
        slot_owner[free_slot]  = r.owner_id;
      end
    end else begin
      res.status = ST_NOT_FOUND;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (res.status == ST_NOT_FOUND && slot_valid[i] && slot_start[i] == r.range_start &&
            slot_length[i] == r.range_length && slot_owner[i] == r.owner_id) begin
          slot_valid[i] = 1'b0;
          res.status    = ST_DONE;
        end
      end
    end
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_valid[i]) n++;
    res.locks_held = (n > int'(HELD_MAX)) ? HELD_MAX : n[HELD_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
      pending_rsp.delete();
    end else begin
      // response first: it always belongs to an older request
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected response, expected none, got status %0d locks %0d",
                   $time, rsp.status, rsp.locks_held);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, rsp.status);
          end
          if (rsp.locks_held !== want.locks_held) begin
            errors++;
            $display("%0t: locks_held mismatch, expected %0d, got %0d",
                     $time, want.locks_held, rsp.locks_held);
          end
        end
      end
      if (req_valid && req_ready)
        pending_rsp.push_back(resolve_request(req));
    end
    outstanding <= pending_rsp.size();
    fail_count  <= errors;
  end

endmodule
`default_nettype wire

[verif/tb_top.sv]
// Testbench top: drives lock requests and response backpressure, reports the verdict.
`default_nettype none
module tb_top;
  import brlt_pkg::*;

  // traffic mix of one round of random requests
  typedef enum int {
    MIX_FILL,     // one or two owners, mostly acquires: drives the table to full
    MIX_CONTEND,  // a few owners in a narrow window: conflicts and exact releases
    MIX_WIDE,     // every field at full random width
    MIX_DRAIN     // mostly releases of recently requested ranges
  } mix_t;

  localparam int TABLE_ENTRIES = 16;
  localparam int RANDOM_WORDS  = 900;
  localparam int ROUND_WORDS   = 30;
  localparam int HOLD_AT       = 450;  // sender waits out all responses here
  localparam int CALM_FROM     = 760;  // no idling on either side from here on
  localparam int DRAIN_CYCLES  = 40;   // idle tail before the verdict
  localparam int LOG_DEPTH     = 40;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  int   fail_count;
  int   outstanding;
  bit   calm     = 1'b0;
  int   gap_odds = 3;   // 0: no sender gaps this round
  req_t acq_log[$];     // recent acquires, source of matching releases

  byte_range_lock_table_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  brlt_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: ready drops in random bursts until the calm tail.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic logic [OFFSET_FIELD_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[OFFSET_FIELD_W-1:0];
  endfunction

  function automatic req_t mk_word(input op_t op, input logic [OWNER_FIELD_W-1:0] own,
                                   input logic [OFFSET_FIELD_W-1:0] start,
                                   input logic [OFFSET_FIELD_W-1:0] len);
    req_t w;
    w.operation    = op;
    w.owner_id     = own;
    w.range_start  = start;
    w.range_length = len;
    return w;
  endfunction

  // One random request of the given mix, clustered around base so that
  // ranges actually meet.
  function automatic req_t random_word(input mix_t mix, input logic [OFFSET_FIELD_W-1:0] base);
    req_t w;
    int   acq_pct;
    acq_pct = 60;
    w = mk_word(OP_ACQUIRE, OWNER_FIELD_W'($urandom_range(0, 3)),
                base + OFFSET_FIELD_W'($urandom_range(0, 63)),
                OFFSET_FIELD_W'($urandom_range(0, 16)));
    case (mix)
      MIX_FILL: begin
        acq_pct    = 85;
        w.owner_id = OWNER_FIELD_W'($urandom_range(0, 1));
      end
      MIX_CONTEND: acq_pct = 60;
      MIX_WIDE: begin
        acq_pct        = 50;
        w.owner_id     = OWNER_FIELD_W'($urandom_range(0, 255));
        w.range_start  = rand48();
        w.range_length = rand48();
      end
      default: acq_pct = 20;
    endcase
    if ($urandom_range(0, 99) >= acq_pct) begin
      // release: usually an exact copy of a recent acquire
      if (acq_log.size() != 0 && $urandom_range(0, 9) < 8)
        w = acq_log[$urandom_range(0, acq_log.size() - 1)];
      w.operation = OP_RELEASE;
    end
    return w;
  endfunction

  // Holds the word until accepted; may idle first.
  task automatic send_word(input req_t w);
    int gap;
    if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      gap = $urandom_range(1, 10);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (w.operation == OP_ACQUIRE) begin
      acq_log.push_back(w);
      if (acq_log.size() > LOG_DEPTH) void'(acq_log.pop_front());
    end
  endtask

  // Sender goes quiet until every response is back.
  task automatic hold_until_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    mix_t                      mix;
    logic [OFFSET_FIELD_W-1:0] base;
    mix  = MIX_FILL;
    base = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // release on an empty table
    send_word(mk_word(OP_RELEASE, 8'd0, 48'd0, 48'd0));
    // zero-length range at 0, then a foreign range starting there: disjoint
    send_word(mk_word(OP_ACQUIRE, 8'd0, 48'd0, 48'd0));
    send_word(mk_word(OP_ACQUIRE, 8'd1, 48'd0, 48'd10));
    // zero-length range strictly inside a foreign range: conflict
    send_word(mk_word(OP_ACQUIRE, 8'd0, 48'd5, 48'd0));
    // adjacent range of another owner, then overlap by the same owner
    send_word(mk_word(OP_ACQUIRE, 8'd2, 48'd10, 48'd5));
    send_word(mk_word(OP_ACQUIRE, 8'd1, 48'd2, 48'd3));
    // top of the offset space: end needs the extra bit
    send_word(mk_word(OP_ACQUIRE, 8'hFF, {OFFSET_FIELD_W{1'b1}}, {OFFSET_FIELD_W{1'b1}}));
    // the whole space by a new owner: conflict
    send_word(mk_word(OP_ACQUIRE, 8'd4, 48'd0, {OFFSET_FIELD_W{1'b1}}));
    send_word(mk_word(OP_RELEASE, 8'd1, 48'd0, 48'd10));
    // duplicates: each release takes one copy, the third finds none
    send_word(mk_word(OP_ACQUIRE, 8'd5, 48'd100, 48'd8));
    send_word(mk_word(OP_ACQUIRE, 8'd5, 48'd100, 48'd8));
    send_word(mk_word(OP_RELEASE, 8'd5, 48'd100, 48'd8));
    send_word(mk_word(OP_RELEASE, 8'd5, 48'd100, 48'd8));
    send_word(mk_word(OP_RELEASE, 8'd5, 48'd100, 48'd8));
    // fill the table with one owner's overlapping ranges
    repeat (TABLE_ENTRIES - 4) send_word(mk_word(OP_ACQUIRE, 8'd6, 48'd2000, 48'd4));
    // full and conflicting: conflict wins; then plain full
    send_word(mk_word(OP_ACQUIRE, 8'd7, 48'd2001, 48'd1));
    send_word(mk_word(OP_ACQUIRE, 8'd6, 48'd2000, 48'd4));
    send_word(mk_word(OP_RELEASE, 8'd6, 48'd2000, 48'd4));
    hold_until_idle();

    // ---- random part, in rounds with their own mix, window and gap rate ----
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % ROUND_WORDS == 0) begin
        mix = mix_t'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0:       base = '0;
          1:       base = 48'h8000_0000_0000;
          2:       base = 48'hFFFF_FFFF_FFC0;
          default: base = rand48();
        endcase
        gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      end
      if (n == CALM_FROM) calm = 1'b1;
      if (n == HOLD_AT) hold_until_idle();
      send_word(random_word(mix, base));
    end

    hold_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/brlt_pkg.sv
rtl/brlt_ram.sv
rtl/brlt_cmp.sv
rtl/byte_range_lock_table_top.sv
rtl/brlt_checker.sv
verif/brlt_checker.sv
verif/tb_top.sv
